>>> sv/bcmc_pkg.sv
// ----------------------------------------------------------------------------
// bcmc_pkg
// Shared types and codes for the battery charge mode controller: charge
// modes, off reasons, register indexes and the packed beat layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package bcmc_pkg;

    // charge modes
    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_SLOW = 2'd1,
        MODE_FAST = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    // power source codes
    localparam logic [1:0] SRC_NONE = 2'd0;
    localparam logic [1:0] SRC_BAD  = 2'd3;

    // off reasons
    typedef enum logic [2:0] {
        RSN_CHARGING = 3'd0,
        RSN_OVERTEMP = 3'd1,
        RSN_COOLDOWN = 3'd2,
        RSN_FULL     = 3'd3,
        RSN_TIMEOUT  = 3'd4,
        RSN_OFF      = 3'd5
    } reason_t;

    // register indexes
    localparam logic [2:0] REG_WARM_LIMIT     = 3'd0;
    localparam logic [2:0] REG_HOT_LIMIT      = 3'd1;
    localparam logic [2:0] REG_CRITICAL_LIMIT = 3'd2;
    localparam logic [2:0] REG_HOT_STOP       = 3'd3;
    localparam logic [2:0] REG_HOT_RESUME     = 3'd4;
    localparam logic [2:0] REG_CHARGE_TIMEOUT = 3'd5;
    localparam logic [2:0] REG_FULL_CURRENT   = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;

    // register reset values
    localparam logic [11:0] WARM_LIMIT_RST     = 12'd450;
    localparam logic [11:0] HOT_LIMIT_RST      = 12'd500;
    localparam logic [11:0] CRITICAL_LIMIT_RST = 12'd600;
    localparam logic [12:0] HOT_STOP_RST       = 13'd4100;
    localparam logic [12:0] HOT_RESUME_RST     = 13'd3800;
    localparam logic [15:0] CHARGE_TIMEOUT_RST = 16'd3600;
    localparam logic [19:0] FULL_CURRENT_RST   = 20'd5000;

    // fixed thresholds
    localparam logic signed [22:0] CHARGE_SEEN_UA = 23'sd1024;
    localparam logic [6:0]         FULL_LEVEL_MIN = 7'd95;
    localparam logic [6:0]         LEVEL_MAX      = 7'd100;

    // input beat, last member in the lowest bits
    typedef struct packed {
        logic [31:0] now_s;
        logic        over_voltage;
        logic [1:0]  power_source;
        logic [12:0] volt_mv;
        logic [11:0] temp_dc;
        logic [6:0]  level_percent;
        logic [22:0] ibat_ua;
    } in_item_t;

    // result beat, last member in the lowest bits
    typedef struct packed {
        reason_t    off_reason;
        logic [6:0] level_out;
        logic       gauge_reset;
        logic       full_flag;
        logic       mode_changed;
        mode_t      mode_out;
    } out_item_t;

    localparam int IN_ITEM_W  = $bits(in_item_t);
    localparam int OUT_ITEM_W = $bits(out_item_t);
    localparam int IN_DATA_W  = ((IN_ITEM_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((OUT_ITEM_W + 7) / 8) * 8;

endpackage

`default_nettype wire

>>> sv/battery_charge_mode_controller.sv
// ----------------------------------------------------------------------------
// battery_charge_mode_controller
// Picks a charge mode per battery poll from source, temperature, voltage,
// current and time, with full detection, cooldown and charge timeout.
// ----------------------------------------------------------------------------
// Usage: each beat on the s_axis channel is one poll; each poll gives exactly
// one result beat on m_axis with the mode, change flag, full flag, gauge
// reset request, level to report and off reason.
// Path: an accepted poll is held in the input register and its result is
// loaded into the output register when the result stage advances, and
// from there it shows on m_axis.
// Throughput: one poll per cycle; the decision is a single pass of compares
// and muxes plus one 33-bit timeout add between the two registers.
// Stall: when m_axis_tready is low the result holds, the input register
// still takes one more poll, then s_axis_tready drops until the result moves.
// Configuration: cfg channel writes one register per beat, always ready;
// write only while no poll is in flight.
// Reset: registers return to their defaults, no mode applied yet, cooldown
// and low-current history cleared, charge seen time zero, both stages empty.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_charge_mode_controller (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // poll input
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // ibat_ua, level_percent, temp_dc, volt_mv, power_source,
    // over_voltage, now_s, zero fill
    input  wire logic [bcmc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // result output
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // mode_out, mode_changed, full_flag, gauge_reset, level_out,
    // off_reason, zero fill
    output logic [bcmc_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    // register write
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [bcmc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [bcmc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bcmc_pkg::*;

    // configuration registers
    logic [11:0] warm_limit_reg;
    logic [11:0] hot_limit_reg;
    logic [11:0] critical_limit_reg;
    logic [12:0] hot_stop_reg;
    logic [12:0] hot_resume_reg;
    logic [15:0] charge_timeout_reg;
    logic [19:0] full_current_reg;

    // controller state
    logic        cooling_reg,          cooling_next;
    logic        prev_low_reg,         prev_low_next;
    mode_t       applied_mode_reg,     applied_mode_next;
    logic [31:0] charge_seen_reg,      charge_seen_next;

    // pipeline registers
    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg,         out_item_next;

    logic        advance;

    // decision signals
    logic signed [22:0] curr;
    logic signed [11:0] temp;
    logic [1:0]  source;
    logic        low;
    logic        full;
    logic        hot_event;
    logic        at_critical;
    logic        at_warm;
    logic        cool_mid;
    logic        charge_seen;
    logic [32:0] deadline;
    logic        timed_out;
    mode_t       mode;
    reason_t     reason;

    assign cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_limit_reg     <= WARM_LIMIT_RST;
            hot_limit_reg      <= HOT_LIMIT_RST;
            critical_limit_reg <= CRITICAL_LIMIT_RST;
            hot_stop_reg       <= HOT_STOP_RST;
            hot_resume_reg     <= HOT_RESUME_RST;
            charge_timeout_reg <= CHARGE_TIMEOUT_RST;
            full_current_reg   <= FULL_CURRENT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WARM_LIMIT:     warm_limit_reg     <= cfg_data[11:0];
                REG_HOT_LIMIT:      hot_limit_reg      <= cfg_data[11:0];
                REG_CRITICAL_LIMIT: critical_limit_reg <= cfg_data[11:0];
                REG_HOT_STOP:       hot_stop_reg       <= cfg_data[12:0];
                REG_HOT_RESUME:     hot_resume_reg     <= cfg_data[12:0];
                REG_CHARGE_TIMEOUT: charge_timeout_reg <= cfg_data[15:0];
                REG_FULL_CURRENT:   full_current_reg   <= cfg_data[19:0];
                default:            ;
            endcase
        end
    end

    // handshake: the result stage loads when empty or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg <= in_item_t'(s_axis_tdata[IN_ITEM_W-1:0]);
        end
    end

    // field decode
    assign curr   = $signed(in_item_reg.ibat_ua);
    assign temp   = $signed(in_item_reg.temp_dc);
    assign source = (in_item_reg.power_source == SRC_BAD) ? SRC_NONE
                                                           : in_item_reg.power_source;

    // threshold compares
    assign low         = !curr[22] &&
                         ({1'b0, in_item_reg.ibat_ua[21:0]} < {3'b000, full_current_reg});
    assign full        = low && prev_low_reg &&
                         (in_item_reg.level_percent > FULL_LEVEL_MIN) && (source != SRC_NONE);
    assign hot_event   = (temp >= $signed(hot_limit_reg)) || in_item_reg.over_voltage;
    assign at_critical = temp >= $signed(critical_limit_reg);
    assign at_warm     = temp >= $signed(warm_limit_reg);
    assign charge_seen = curr > CHARGE_SEEN_UA;
    assign deadline    = {1'b0, charge_seen_reg} + {17'd0, charge_timeout_reg};
    assign timed_out   = !charge_seen && (applied_mode_reg != MODE_OFF) &&
                         ({1'b0, in_item_reg.now_s} > deadline);

    // cooldown flag after the hot check, before the resume check
    assign cool_mid = cooling_reg || (hot_event && (in_item_reg.volt_mv >= hot_stop_reg));

    // mode selection in priority order
    always_comb
    begin
        mode         = mode_t'(source);
        cooling_next = cool_mid;
        if (full)
        begin
            mode = MODE_OFF;
        end
        if (hot_event && at_critical)
        begin
            mode = MODE_OFF;
        end
        if (at_warm && (mode == MODE_FAST))
        begin
            mode = MODE_SLOW;
        end
        if (cool_mid)
        begin
            if (!at_warm || (in_item_reg.volt_mv <= hot_resume_reg))
            begin
                cooling_next = 1'b0;
            end
            else
            begin
                mode = MODE_OFF;
            end
        end
        if (timed_out || (source == SRC_NONE))
        begin
            mode = MODE_OFF;
        end
    end

    // off reason
    always_comb
    begin
        if (mode != MODE_OFF)
        begin
            reason = RSN_CHARGING;
        end
        else if (at_critical)
        begin
            reason = RSN_OVERTEMP;
        end
        else if (cooling_next)
        begin
            reason = RSN_COOLDOWN;
        end
        else if (full)
        begin
            reason = RSN_FULL;
        end
        else if (timed_out)
        begin
            reason = RSN_TIMEOUT;
        end
        else
        begin
            reason = RSN_OFF;
        end
    end

    // next state and result
    always_comb
    begin
        prev_low_next     = low;
        applied_mode_next = mode;
        charge_seen_next  = charge_seen_reg;
        if (charge_seen || ((applied_mode_reg != mode) && (mode != MODE_OFF)))
        begin
            charge_seen_next = in_item_reg.now_s;
        end

        out_item_next.mode_out     = mode;
        out_item_next.mode_changed = applied_mode_reg != mode;
        out_item_next.full_flag    = full;
        out_item_next.gauge_reset  = full;
        out_item_next.level_out    = (full || (in_item_reg.level_percent > LEVEL_MAX))
                                     ? LEVEL_MAX : in_item_reg.level_percent;
        out_item_next.off_reason   = reason;
    end

    // state update, one poll per advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cooling_reg      <= 1'b0;
            prev_low_reg     <= 1'b0;
            applied_mode_reg <= MODE_NONE;
            charge_seen_reg  <= 32'd0;
        end
        else if (advance)
        begin
            cooling_reg      <= cooling_next;
            prev_low_reg     <= prev_low_next;
            applied_mode_reg <= applied_mode_next;
            charge_seen_reg  <= charge_seen_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - OUT_ITEM_W){1'b0}}, out_item_reg};

`ifndef NO_ASSERTIONS
    // a delivered result never carries the no-mode-yet code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_item_reg.mode_out != MODE_NONE))
        else $error("result mode is the unapplied code");

    // the reason is charging exactly when a charge mode is chosen
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            ((out_item_reg.mode_out == MODE_OFF) == (out_item_reg.off_reason != RSN_CHARGING)))
        else $error("off reason disagrees with mode");

    // full detection turns charging off and reports a full level
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_item_reg.full_flag) |->
            ((out_item_reg.mode_out == MODE_OFF) && (out_item_reg.level_out == LEVEL_MAX)
             && out_item_reg.gauge_reset))
        else $error("full result is not off at full level");

    // applied mode follows the last decision loaded into the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (applied_mode_reg == out_item_reg.mode_out))
        else $error("applied mode out of step with result");
`endif

endmodule

`default_nettype wire
